### rtl/core/ilm_pkg.sv
package ilm_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_SNAPSHOT = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  // Picoseconds per second; fits in 40 bits.
  localparam int unsigned PS_W = 40;
  localparam logic [PS_W-1:0] PS_PER_SEC = 40'd1000000000000;

  // Number of quotient bits the divider produces.
  localparam int unsigned DIV_STEPS = 64;

  // One outstanding request as stored in the table memory.
  typedef struct packed {
    logic [31:0] id;
    logic [63:0] stamp;
    logic [31:0] len;
  } entry_t;

  // Divider status seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB,
    S_CRD,
    S_CCMP,
    S_MUL1,
    S_MUL2,
    S_UPD,
    S_SNAP,
    S_PM1,
    S_PM2,
    S_PM3,
    S_CHK,
    S_DIV,
    S_CLR,
    S_OUT
  } state_t;

endpackage

### rtl/core/ilm_table.sv
module ilm_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  ilm_pkg::entry_t   wr_data,
  input  logic              clr_en,
  input  logic [IDX_W-1:0]  clr_addr,
  input  logic [IDX_W-1:0]  rd_addr,
  output ilm_pkg::entry_t   rd_data,
  output logic              rd_vld,
  output logic              full,
  output logic [IDX_W-1:0]  free_idx
);
  import ilm_pkg::*;

  entry_t            mem [DEPTH];
  entry_t            rd_data_r;
  logic              rd_vld_r;
  logic [DEPTH-1:0]  valid_r;

  // Entry storage with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Valid bits: set on write, cleared when a completion frees the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_addr] <= 1'b0;
      end
    end
  end

  // Lowest free slot and full flag.
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign full    = &valid_r;
  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

### rtl/core/ilm_div.sv
module ilm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          dvd_hi,
  input  logic [63:0]          dvd_lo,
  input  logic [63:0]          dvs,
  output logic [63:0]          quo,
  output ilm_pkg::div_status_t stat
);
  import ilm_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic [63:0]   rem_r;
  logic [63:0]   lo_r;
  logic [63:0]   q_r;
  logic [63:0]   dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [63:0]   rem_sh;
  logic          take;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_r[62:0], lo_r[63]};
    take   = rem_r[63] || (rem_sh >= dvs_r);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dvd_hi;
      lo_r  <= dvd_lo;
      dvs_r <= dvs;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= take ? rem_sh - dvs_r : rem_sh;
      lo_r  <= {lo_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], take};
    end
  end

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### rtl/core/io_latency_monitor.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    command, now, io_id, io_length
// out_      output     out_valid / out_stall  status, latency and statistics
//
// Submit writes the lowest free slot of the table memory.
// Completion searches the table memory one entry at a time, scanning 1 to depth slots.
// Snapshot runs its divisions on the 64-step shared divider.
// Reset is synchronous and clears all valid bits at once; the next item can
// be taken while a finished result waits on out_stall.
module io_latency_monitor #(
  parameter int unsigned OUTSTANDING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_now,
  input  logic [31:0] in_io_id,
  input  logic [31:0] in_io_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_latency,
  output logic [63:0] out_min_latency,
  output logic [63:0] out_max_latency,
  output logic [63:0] out_latency_sum,
  output logic [63:0] out_latency_square_sum,
  output logic [63:0] out_submitted_count,
  output logic [63:0] out_rate_iops,
  output logic [63:0] out_rate_bandwidth,
  output logic [63:0] out_interval_avg_latency
);
  import ilm_pkg::*;

  localparam int unsigned IDX_W = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUTSTANDING_DEPTH + 1);

  state_t      state_r, state_nxt;
  cmd_t        cmd_r;
  logic [63:0] now_r;
  logic [31:0] id_r;
  logic [31:0] len_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0] tick_r;
  status_t     status_r;
  logic [63:0] latency_r;
  logic [63:0] prod_a_r, prod_b_r;
  logic [PS_W+31:0] pm_lo_r, pm_hi_r;
  logic [127:0] dvd_r;
  logic [63:0] diff_r;
  logic [1:0]  phase_r;
  logic [63:0] iops_r, bw_r, avg_r;

  // Running statistics.
  logic [63:0] lat_min_r, lat_max_r, lat_total_r, lat_sq_r, submit_total_r;
  logic [63:0] int_done_r, int_bytes_r, int_lat_r, last_snap_r;

  // Output register.
  logic        out_valid_r;
  status_t     o_status_r;
  logic [63:0] o_latency_r, o_min_r, o_max_r, o_sum_r, o_sq_r, o_sub_r;
  logic [63:0] o_iops_r, o_bw_r, o_avg_r;

  // Table and divider connections.
  logic             tbl_wr_en, tbl_clr_en, tbl_rd_vld, tbl_full;
  logic [IDX_W-1:0] tbl_free_idx, scan_idx;
  entry_t           tbl_wr_data, tbl_rd_data;
  logic             div_start;
  logic [63:0]      div_quo, div_dvs;
  div_status_t      div_stat;

  logic        in_xfer, out_load, match, last_slot;
  logic [63:0] pm_op, diff_now;

  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign scan_idx  = cnt_r[IDX_W-1:0];
  assign match     = tbl_rd_vld && (tbl_rd_data.id == id_r);
  assign last_slot = (cnt_r == CNT_W'(OUTSTANDING_DEPTH - 1));
  assign pm_op     = (phase_r == 2'd0) ? int_done_r : int_bytes_r;
  assign diff_now  = now_r - last_snap_r;
  assign div_dvs   = (phase_r == 2'd2) ? int_done_r : diff_r;

  ilm_table #(
    .DEPTH (OUTSTANDING_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_free_idx),
    .wr_data  (tbl_wr_data),
    .clr_en   (tbl_clr_en),
    .clr_addr (scan_idx),
    .rd_addr  (scan_idx),
    .rd_data  (tbl_rd_data),
    .rd_vld   (tbl_rd_vld),
    .full     (tbl_full),
    .free_idx (tbl_free_idx)
  );

  ilm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .dvd_hi (dvd_r[127:64]),
    .dvd_lo (dvd_r[63:0]),
    .dvs    (div_dvs),
    .quo    (div_quo),
    .stat   (div_stat)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_t'(in_command))
            CMD_SUBMIT:   state_nxt = S_SUB;
            CMD_COMPLETE: state_nxt = S_CRD;
            CMD_SNAPSHOT: state_nxt = S_SNAP;
            default:      state_nxt = S_OUT;
          endcase
        end
      end
      S_SUB:  state_nxt = S_OUT;
      S_CRD:  state_nxt = S_CCMP;
      S_CCMP: state_nxt = (match || last_slot) ? S_MUL1 : S_CRD;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OUT;
      S_SNAP: state_nxt = (diff_now == 64'd0) ? S_OUT : S_PM1;
      S_PM1:  state_nxt = S_PM2;
      S_PM2:  state_nxt = S_PM3;
      S_PM3:  state_nxt = S_CHK;
      S_CHK: begin
        if ((phase_r == 2'd2 && int_done_r == 64'd0) || dvd_r[127:64] >= div_dvs) begin
          state_nxt = (phase_r == 2'd2) ? S_CLR : S_PM1;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = (phase_r == 2'd2) ? S_CLR : S_PM1;
        end
      end
      S_CLR:  state_nxt = S_OUT;
      S_OUT:  state_nxt = out_load ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_stall    = (state_r != S_IDLE);
    tbl_wr_en   = (state_r == S_SUB) && !tbl_full;
    tbl_clr_en  = (state_r == S_CCMP) && match;
    div_start   = (state_r == S_CHK) && (state_nxt == S_DIV);
    tbl_wr_data.id    = id_r;
    tbl_wr_data.stamp = now_r;
    tbl_wr_data.len   = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item datapath: capture, search, products and divisions.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_r     <= cmd_t'(in_command);
          now_r     <= in_now;
          id_r      <= in_io_id;
          len_r     <= in_io_length;
          cnt_r     <= '0;
          phase_r   <= 2'd0;
          status_r  <= ST_OK;
          latency_r <= '0;
          iops_r    <= '0;
          bw_r      <= '0;
          avg_r     <= '0;
        end
      end
      S_SUB: begin
        if (tbl_full) begin
          status_r <= ST_FULL;
        end
      end
      S_CCMP: begin
        if (match) begin
          tick_r    <= now_r - tbl_rd_data.stamp;
          latency_r <= now_r - tbl_rd_data.stamp;
        end else if (last_slot) begin
          tick_r   <= now_r;
          status_r <= ST_NOT_FOUND;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_MUL1: prod_a_r <= tick_r[31:0] * tick_r[31:0];
      S_MUL2: prod_b_r <= tick_r[31:0] * tick_r[63:32];
      S_SNAP: diff_r <= diff_now;
      S_PM1:  pm_lo_r <= pm_op[31:0] * PS_PER_SEC;
      S_PM2:  pm_hi_r <= pm_op[63:32] * PS_PER_SEC;
      S_PM3: begin
        if (phase_r == 2'd2) begin
          dvd_r <= {64'd0, int_lat_r};
        end else begin
          dvd_r <= 128'(pm_lo_r) + (128'(pm_hi_r) << 32);
        end
      end
      S_CHK: begin
        if (state_nxt != S_DIV) begin
          if (phase_r == 2'd0) begin
            iops_r <= '1;
          end else if (phase_r == 2'd1) begin
            bw_r <= '1;
          end
          if (phase_r != 2'd2) begin
            phase_r <= phase_r + 2'd1;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          case (phase_r)
            2'd0:    iops_r <= div_quo;
            2'd1:    bw_r   <= div_quo;
            default: avg_r  <= div_quo;
          endcase
          if (phase_r != 2'd2) begin
            phase_r <= phase_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Running statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_min_r      <= '1;
      lat_max_r      <= '0;
      lat_total_r    <= '0;
      lat_sq_r       <= '0;
      submit_total_r <= '0;
      int_done_r     <= '0;
      int_bytes_r    <= '0;
      int_lat_r      <= '0;
      last_snap_r    <= '0;
    end else begin
      if (tbl_wr_en) begin
        submit_total_r <= submit_total_r + 64'd1;
      end
      if (tbl_clr_en) begin
        int_done_r  <= int_done_r + 64'd1;
        int_bytes_r <= int_bytes_r + 64'(tbl_rd_data.len);
        int_lat_r   <= int_lat_r + (now_r - tbl_rd_data.stamp);
      end
      if (state_r == S_UPD) begin
        if (lat_min_r > tick_r) begin
          lat_min_r <= tick_r;
        end
        if (lat_max_r < tick_r) begin
          lat_max_r <= tick_r;
        end
        lat_total_r <= lat_total_r + tick_r;
        lat_sq_r    <= lat_sq_r + prod_a_r + {prod_b_r[30:0], 33'd0};
      end
      if (state_r == S_CLR) begin
        int_done_r  <= '0;
        int_bytes_r <= '0;
        int_lat_r   <= '0;
        last_snap_r <= now_r;
      end
    end
  end

  // Output register: holds a finished result until it is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r  <= status_r;
      o_latency_r <= latency_r;
      o_min_r     <= lat_min_r;
      o_max_r     <= lat_max_r;
      o_sum_r     <= lat_total_r;
      o_sq_r      <= lat_sq_r;
      o_sub_r     <= submit_total_r;
      o_iops_r    <= iops_r;
      o_bw_r      <= bw_r;
      o_avg_r     <= avg_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = o_status_r;
  assign out_latency              = o_latency_r;
  assign out_min_latency          = o_min_r;
  assign out_max_latency          = o_max_r;
  assign out_latency_sum          = o_sum_r;
  assign out_latency_square_sum   = o_sq_r;
  assign out_submitted_count      = o_sub_r;
  assign out_rate_iops            = o_iops_r;
  assign out_rate_bandwidth       = o_bw_r;
  assign out_interval_avg_latency = o_avg_r;

`ifndef NO_ASSERTIONS
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_tbl_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_wr_en && tbl_clr_en))
    else $error("table write and clear in the same cycle");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("result load did not return to idle");

  a_clear_only_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (cmd_r == CMD_SNAPSHOT))
    else $error("interval clear outside a snapshot");
`endif

endmodule

### bench/io_latency_monitor_test.sv
module io_latency_monitor_test;
  import ilm_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [63:0] PS_SEC = 64'd1000000000000;

  // One result as the block reports it.
  typedef struct {
    logic [1:0]  status;
    logic [63:0] latency;
    logic [63:0] min_lat;
    logic [63:0] max_lat;
    logic [63:0] lat_sum;
    logic [63:0] lat_sq_sum;
    logic [63:0] submitted;
    logic [63:0] iops;
    logic [63:0] bandwidth;
    logic [63:0] avg_lat;
  } stats_t;

  // Latency statistics tracker with its own copy of the request table.
  class latency_scoreboard;
    bit          slot_busy[DEPTH];
    logic [31:0] slot_id[DEPTH];
    logic [63:0] slot_stamp[DEPTH];
    logic [31:0] slot_len[DEPTH];
    logic [63:0] lat_min, lat_max, lat_sum, lat_sq, sub_total;
    logic [63:0] ivl_done, ivl_bytes, ivl_lat, last_snap;
    stats_t      pending[$];
    int          errors;

    function void clear();
      foreach (slot_busy[i]) slot_busy[i] = 0;
      lat_min = '1;
      lat_max = 0;
      lat_sum = 0;
      lat_sq = 0;
      sub_total = 0;
      ivl_done = 0;
      ivl_bytes = 0;
      ivl_lat = 0;
      last_snap = 0;
      pending.delete();
      errors = 0;
    endfunction

    // Exact floor(count * 10^12 / elapsed), saturated to 64 bits.
    function logic [63:0] per_second(logic [63:0] count, logic [63:0] elapsed);
      logic [127:0] q;
      q = ({64'd0, count} * {64'd0, PS_SEC}) / {64'd0, elapsed};
      return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function int free_slots();
      int n;
      n = 0;
      foreach (slot_busy[i]) if (!slot_busy[i]) n++;
      return n;
    endfunction

    function void note_request(cmd_t cmd, logic [63:0] now, logic [31:0] id,
                               logic [31:0] len);
      stats_t r;
      int slot;
      logic [63:0] tick;
      r = '{default: 0};
      slot = -1;
      case (cmd)
        CMD_SUBMIT: begin
          foreach (slot_busy[i]) if (slot < 0 && !slot_busy[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_busy[slot] = 1;
            slot_id[slot] = id;
            slot_stamp[slot] = now;
            slot_len[slot] = len;
            sub_total++;
          end
        end
        CMD_COMPLETE: begin
          tick = now;
          foreach (slot_busy[i])
            if (slot < 0 && slot_busy[i] && slot_id[i] == id) slot = i;
          if (slot < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            tick = now - slot_stamp[slot];
            r.latency = tick;
            ivl_done++;
            ivl_bytes += slot_len[slot];
            ivl_lat += tick;
            slot_busy[slot] = 0;
          end
          if (lat_min > tick) lat_min = tick;
          if (lat_max < tick) lat_max = tick;
          lat_sum += tick;
          lat_sq += tick * tick;
        end
        CMD_SNAPSHOT: begin
          tick = now - last_snap;
          if (tick != 0) begin
            r.iops = per_second(ivl_done, tick);
            r.bandwidth = per_second(ivl_bytes, tick);
            r.avg_lat = (ivl_done != 0) ? ivl_lat / ivl_done : 0;
            ivl_done = 0;
            ivl_bytes = 0;
            ivl_lat = 0;
            last_snap = now;
          end
        end
        default: ;
      endcase
      r.min_lat = lat_min;
      r.max_lat = lat_max;
      r.lat_sum = lat_sum;
      r.lat_sq_sum = lat_sq;
      r.submitted = sub_total;
      pending = {pending, r};
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(stats_t a);
      stats_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, a.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("status", e.status, a.status);
      check_field("latency", e.latency, a.latency);
      check_field("min_latency", e.min_lat, a.min_lat);
      check_field("max_latency", e.max_lat, a.max_lat);
      check_field("latency_sum", e.lat_sum, a.lat_sum);
      check_field("latency_square_sum", e.lat_sq_sum, a.lat_sq_sum);
      check_field("submitted_count", e.submitted, a.submitted);
      check_field("rate_iops", e.iops, a.iops);
      check_field("rate_bandwidth", e.bandwidth, a.bandwidth);
      check_field("interval_avg_latency", e.avg_lat, a.avg_lat);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [63:0] in_now;
  logic [31:0] in_io_id;
  logic [31:0] in_io_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [63:0] out_latency;
  logic [63:0] out_min_latency;
  logic [63:0] out_max_latency;
  logic [63:0] out_latency_sum;
  logic [63:0] out_latency_square_sum;
  logic [63:0] out_submitted_count;
  logic [63:0] out_rate_iops;
  logic [63:0] out_rate_bandwidth;
  logic [63:0] out_interval_avg_latency;

  latency_scoreboard board;
  bit          quiet_tail;
  bit          hold_off;
  logic [63:0] clock_ps;
  logic [31:0] id_pool[$];

  io_latency_monitor dut (.*);

  // Free-running clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #40000000;
    $display("io_latency_monitor_test: done, errors");
    $finish;
  end

  // Receiver side: random stall bursts, plus a long hold-off on request.
  initial begin
    int n;
    out_stall = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // Result checking at each accepted transfer.
  always @(posedge clk) begin
    stats_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.status = out_status;
      a.latency = out_latency;
      a.min_lat = out_min_latency;
      a.max_lat = out_max_latency;
      a.lat_sum = out_latency_sum;
      a.lat_sq_sum = out_latency_square_sum;
      a.submitted = out_submitted_count;
      a.iops = out_rate_iops;
      a.bandwidth = out_rate_bandwidth;
      a.avg_lat = out_interval_avg_latency;
      board.check_result(a);
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send(cmd_t cmd, logic [63:0] now, logic [31:0] id, logic [31:0] len);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_now <= now;
    in_io_id <= id;
    in_io_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(cmd, now, id, len);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return $urandom_range(0, 4096);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic: submits and completions of live ids, rare snapshots.
  task automatic random_item();
    int pick, k;
    logic [31:0] id;
    clock_ps += $urandom_range(1, 5000);
    if ($urandom_range(0, 15) == 0) clock_ps += {$urandom, $urandom} >> $urandom_range(8, 40);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send(CMD_SNAPSHOT, clock_ps, $urandom, $urandom);
    end else if (pick < 5) begin
      send(CMD_NONE, {$urandom, $urandom}, $urandom, $urandom);
    end else if (pick < 10) begin
      send(CMD_COMPLETE, {$urandom, $urandom}, $urandom, $urandom);
    end else if (pick < 50 && id_pool.size() < 70) begin
      id = ($urandom_range(0, 7) == 0 && id_pool.size() > 0) ? id_pool[0] : $urandom;
      send(CMD_SUBMIT, clock_ps, id, rand_len());
      if (board.pending[$].status == ST_OK) id_pool = {id_pool, id};
    end else if (id_pool.size() > 0) begin
      k = $urandom_range(0, id_pool.size() - 1);
      send(CMD_COMPLETE, clock_ps, id_pool[k], $urandom);
      if (board.pending[$].status == ST_OK) id_pool.delete(k);
    end else begin
      send(CMD_SUBMIT, clock_ps, $urandom, rand_len());
      id_pool = {id_pool, in_io_id};
    end
  endtask

  initial begin
    int cycles;
    board = new();
    board.clear();
    quiet_tail = 0;
    hold_off = 0;
    clock_ps = 0;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_NONE;
    in_now = 0;
    in_io_id = 0;
    in_io_length = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: snapshot at time zero, field extremes, misses, duplicates.
    send(CMD_SNAPSHOT, 64'd0, 32'd0, 32'd0);
    send(CMD_COMPLETE, 64'd77, 32'd5, 32'd0);
    send(CMD_SUBMIT, 64'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_SUBMIT, 64'd200, 32'd0, 32'd0);
    send(CMD_SUBMIT, 64'd300, 32'd0, 32'd512);
    send(CMD_COMPLETE, 64'd1000, 32'd0, 32'hFFFF_FFFF);
    send(CMD_COMPLETE, 64'd1500, 32'd0, 32'd0);
    send(CMD_COMPLETE, 64'd50, 32'hFFFF_FFFF, 32'd0);
    send(CMD_NONE, '1, '1, '1);
    send(CMD_SNAPSHOT, 64'd2000, 32'd0, 32'd0);
    send(CMD_SNAPSHOT, 64'd2000, 32'd0, 32'd0);
    send(CMD_SUBMIT, 64'd2001, 32'h1234, 32'hFFFF_FFFF);
    send(CMD_COMPLETE, '1, 32'h1234, 32'd0);
    send(CMD_SNAPSHOT, 64'd2002, 32'd0, 32'd0);
    send(CMD_SNAPSHOT, '1, 32'd0, 32'd0);
    send(CMD_COMPLETE, '1, 32'hDEAD_BEEF, 32'd0);
    send(CMD_SNAPSHOT, 64'd0, 32'd0, 32'd0);
    clock_ps = 64'd10;

    // Fill the table past full while the receiver holds off.
    hold_off = 1;
    repeat (DEPTH + 2) begin
      clock_ps += $urandom_range(1, 100);
      send(CMD_SUBMIT, clock_ps, $urandom, rand_len());
      if (board.pending[$].status == ST_OK) id_pool = {id_pool, in_io_id};
    end

    // Pause until everything has drained.
    go_idle();
    cycles = 0;
    while ((board.pending.size() != 0 || hold_off) && cycles < 100000) begin
      @(posedge clk);
      cycles++;
    end

    repeat (1520) random_item();
    quiet_tail = 1;
    repeat (100) random_item();
    go_idle();

    cycles = 0;
    while (board.pending.size() != 0 && cycles < 200000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("io_latency_monitor_test: done, clean");
    else
      $display("io_latency_monitor_test: done, errors");
    $finish;
  end
endmodule
